// ===== rtl/core/zeck_pkg.sv =====
// Shared types, constants and the Fibonacci table for the Zeckendorf encoder.
// Depends on nothing; every other file of the block imports it.
package zeck_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = 6;
  localparam int FIB_COUNT   = 48;

  localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(FIB_COUNT - 1);
  localparam logic [IDX_W-1:0] MIN_IDX = IDX_W'(2);
  localparam logic [IDX_W-1:0] ZERO_IDX = IDX_W'(0);

  // Only the low VALUE_WIDTH bits of an input word take part.
  localparam logic [DATA_W-1:0] VALUE_MASK = (VALUE_WIDTH >= DATA_W) ? {DATA_W{1'b1}} :
                                             DATA_W'((64'd1 << VALUE_WIDTH) - 64'd1);

  localparam logic [DATA_W-1:0] FIB_TABLE [FIB_COUNT] = '{
    32'd0, 32'd1, 32'd1, 32'd2, 32'd3, 32'd5, 32'd8, 32'd13, 32'd21, 32'd34,
    32'd55, 32'd89, 32'd144, 32'd233, 32'd377, 32'd610, 32'd987, 32'd1597,
    32'd2584, 32'd4181, 32'd6765, 32'd10946, 32'd17711, 32'd28657, 32'd46368,
    32'd75025, 32'd121393, 32'd196418, 32'd317811, 32'd514229, 32'd832040,
    32'd1346269, 32'd2178309, 32'd3524578, 32'd5702887, 32'd9227465,
    32'd14930352, 32'd24157817, 32'd39088169, 32'd63245986, 32'd102334155,
    32'd165580141, 32'd267914296, 32'd433494437, 32'd701408733,
    32'd1134903170, 32'd1836311903, 32'd2971215073
  };

  function automatic logic [DATA_W-1:0] fib_value(input logic [IDX_W-1:0] k);
    logic [DATA_W-1:0] f;
    f = '0;
    if (k <= TOP_IDX) begin
      f = FIB_TABLE[k];
    end
    return f;
  endfunction

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fits;
    logic is_last;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/zeck_in_if.sv =====
// Input channel of the Zeckendorf encoder: valid/ready with one value word.
// Depends on zeck_pkg for the data width.
interface zeck_in_if import zeck_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// ===== rtl/core/zeck_out_if.sv =====
// Output channel of the Zeckendorf encoder: valid/ready with one term word.
// Depends on zeck_pkg for the field widths.
interface zeck_out_if import zeck_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] term;
  logic [IDX_W-1:0]  fib_index;
  logic              last;

  modport source (output valid, output term, output fib_index, output last, input ready);
  modport sink (input valid, input term, input fib_index, input last, output ready);
endinterface

// ===== rtl/core/zeck_ctrl.sv =====
// Controller of the Zeckendorf encoder: takes a word, then walks the index down
// and tells the datapath when to emit a term. Depends on zeck_pkg.
module zeck_ctrl import zeck_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.fits) begin
          // A term is ready; it waits here until the output register frees up.
          if (stat.out_free) begin
            cmd.emit = 1'b1;
            if (stat.is_last) begin
              state_next = ST_IDLE;
            end
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/zeck_dp.sv =====
// Datapath of the Zeckendorf encoder: remainder and index registers, the
// compare-subtract against the Fibonacci table, and the output register.
// Depends on zeck_pkg.
module zeck_dp import zeck_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [DATA_W-1:0] value,
  input  cmd_t              cmd,
  output stat_t             stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] term,
  output logic [IDX_W-1:0]  fib_index,
  output logic              last
);

  logic [DATA_W-1:0] rem;
  logic [IDX_W-1:0]  k;
  logic [DATA_W-1:0] fib_k;
  logic              rem_zero;

  assign fib_k    = fib_value(k);
  assign rem_zero = (rem == '0);

  // A zero word is only seen before its first term and yields a single zero term.
  assign stat.fits     = rem_zero || (fib_k <= rem) || (k == MIN_IDX);
  assign stat.is_last  = rem_zero || (rem == fib_k);
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem <= value & VALUE_MASK;
      k   <= TOP_IDX;
    end else if (cmd.emit) begin
      // The next term is at least two places lower, so stepping down at once is safe.
      rem <= rem - fib_k;
      k   <= k - IDX_W'(1);
    end else if (cmd.step) begin
      k <= k - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      term      <= rem_zero ? '0 : fib_k;
      fib_index <= rem_zero ? ZERO_IDX : k;
      last      <= stat.is_last;
    end
  end

endmodule

// ===== rtl/core/zeckendorf_encoder.sv =====
// Channel   Role   Word
// value_ch  sink   value[31:0]
// term_ch   source term[31:0], fib_index[5:0], last
//
// A word is loaded and then the index walks down from 47 to the index of its
// smallest term, one index per cycle while the output does not stall. The
// index walk lives in the controller and datapath.
// Terms leave through an output register, so the next word can be taken while
// the final term of the previous one still waits. A stalled output holds the
// walk at the pending term. Reset is synchronous and clears the controller and
// the output valid flag.
module zeckendorf_encoder import zeck_pkg::*; (
  input logic              clk,
  input logic              rst,
  zeck_in_if.sink          value_ch,
  zeck_out_if.source       term_ch
);

  cmd_t  cmd;
  stat_t stat;

  zeck_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (value_ch.valid),
    .in_ready (value_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  zeck_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (value_ch.value),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (term_ch.valid),
    .out_ready (term_ch.ready),
    .term      (term_ch.term),
    .fib_index (term_ch.fib_index),
    .last      (term_ch.last)
  );

  // One word at a time: in the cycle after a word is taken, input is closed.
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    value_ch.valid && value_ch.ready |=> !value_ch.ready)
    else $error("input accepted while a word is still being encoded");

  // A term that is not the final one is never below F(4).
  a_nonlast_index: assert property (@(posedge clk) disable iff (rst)
    term_ch.valid && !term_ch.last |-> term_ch.fib_index >= IDX_W'(4))
    else $error("non-final term with too small an index");

  // A zero term only appears alone, as the final term with index zero.
  a_zero_term: assert property (@(posedge clk) disable iff (rst)
    term_ch.valid && (term_ch.term == '0) |-> term_ch.last && (term_ch.fib_index == ZERO_IDX))
    else $error("zero term without last or with nonzero index");

  // Commands are mutually exclusive.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.step, cmd.emit}))
    else $error("controller issued more than one command");

endmodule
